// File: rtl/core/occupancy_summed_area_box_query_macros.svh
// assertion macros shared by the occupancy grid block
// no dependencies; expects clk_i and rst_ni in the including module
`ifndef OCCUPANCY_SUMMED_AREA_BOX_QUERY_MACROS_SVH
`define OCCUPANCY_SUMMED_AREA_BOX_QUERY_MACROS_SVH

// same-cycle implication
`define OSABQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OSABQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/osabq_pkg.sv
// types and constants for the occupancy grid box query block
// no dependencies
package osabq_pkg;

  localparam int CNT_W     = 17;
  localparam int CFG_W     = 9;
  localparam int CRD_W     = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_MARK  = 2'd1,
    MODE_BUILD = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CLEAR  = 6'b000010,
    S_MARK   = 6'b000100,
    S_BUILD  = 6'b001000,
    S_QUERY  = 6'b010000,
    S_RESULT = 6'b100000
  } state_e;

  typedef struct packed {
    mode_e            mode;
    logic [CRD_W-1:0] cell_x;
    logic [CRD_W-1:0] cell_y;
    logic [CRD_W-1:0] box_min_x;
    logic [CRD_W-1:0] box_min_y;
    logic [CRD_W-1:0] box_max_x;
    logic [CRD_W-1:0] box_max_y;
  } in_t;

  typedef struct packed {
    logic             box_empty;
    logic [CNT_W-1:0] occupied_count;
  } out_t;

  // control of the shared accumulate unit
  typedef struct packed {
    logic clr;
    logic en;
    logic sub;
  } acc_ctrl_t;

endpackage

// File: rtl/core/osabq_ram.sv
// generic single-port ram with registered read
// no dependencies
module osabq_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 65536
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/osabq_acc.sv
// shared add/subtract accumulator for build and query
// depends on osabq_pkg
module osabq_acc import osabq_pkg::*; (
  input  logic             clk_i,
  input  acc_ctrl_t        ctrl_i,
  input  logic [CNT_W-1:0] opnd_i,
  output logic [CNT_W-1:0] acc_o
);

  logic [CNT_W-1:0] acc_q, acc_d;

  // arithmetic wraps at the count width
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.en) begin
      acc_d = ctrl_i.sub ? (acc_q - opnd_i) : (acc_q + opnd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// File: rtl/core/occupancy_summed_area_box_query.sv
// top level of the occupancy grid with summed-area box query
// depends on osabq_pkg, osabq_ram, osabq_acc and the macros header
//
// usage
// - item channel: an item is taken at a clock edge with start_i high and
//   busy_o low; item_i.mode picks clear, mark, build or query
// - result channel: a query gives one result on res_o, marked by
//   res_valid_o for exactly one cycle; the receiver cannot stall it, so it
//   must take the result in that cycle; other items give no result
// - config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and
//   cfg_data_i; ready is always high, write only while idle
// item flow, all through the one ram port and the shared accumulator
// - mark: one write, then busy_o drops
// - query: taken from idle, five steps for four reads and their
//   accumulate steps, then a result state; the strobe comes as busy_o drops
// - build: five steps per cell, over every cell in use
//   (two reads, three accumulate steps, one write per cell)
// - clear: one ram entry per cycle over the whole ram
//   (2**(clog2(GRID_X)+clog2(GRID_Y)) entries, 65536 by default)
// reset: the same clearing pass runs right after reset with busy_o high;
//   config writes are taken during it
module occupancy_summed_area_box_query import osabq_pkg::*; #(
  parameter int GRID_X = 256,
  parameter int GRID_Y = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  in_t                  item_i,
  output logic                 res_valid_o,
  output out_t                 res_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

`include "occupancy_summed_area_box_query_macros.svh"

  // grid index widths; ram address is {x, y}
  localparam int XW    = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int YW    = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
  localparam int XSW   = $clog2(GRID_X + 1);
  localparam int YSW   = $clog2(GRID_Y + 1);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 2 ** AW;

  // sequencer steps within one cell or one query
  localparam logic [2:0] STEP0 = 3'd0;
  localparam logic [2:0] STEP1 = 3'd1;
  localparam logic [2:0] STEP2 = 3'd2;
  localparam logic [2:0] STEP3 = 3'd3;
  localparam logic [2:0] STEP4 = 3'd4;

  state_e           state_q, state_d;
  logic [2:0]       ph_q, ph_d;
  logic [AW-1:0]    caddr_q, caddr_d;
  logic [XW-1:0]    px_q, px_d, sx_q, sx_d;
  logic [YW-1:0]    py_q, py_d, sy_q, sy_d;
  logic [3:0]       use_q, use_d;
  logic [CNT_W-1:0] lp_q, lp_d;
  out_t             res_q, res_d;
  logic             res_valid_q, res_valid_d;
  logic [CFG_W-1:0] cols_q, rows_q;

  logic [XSW-1:0]   nx;
  logic [YSW-1:0]   ny;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_addr;
  logic [CNT_W-1:0] ram_wdata, ram_rdata;

  acc_ctrl_t        acc_ctrl;
  logic [CNT_W-1:0] acc_opnd, acc_val;

  // decoded query and mark fields
  logic [XW-1:0]    qx1, qsx;
  logic [YW-1:0]    qy1, qsy;
  logic             qvalid, mark_ok;
  logic             bx_first, by_first, last_x, last_y;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= CFG_W'(256);
      rows_q <= CFG_W'(256);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_COLS: cols_q <= cfg_data_i;
        CFG_ROWS: rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective sizes: zero reads as one, oversize clamps to the grid
  always_comb begin
    if (cols_q == '0) begin
      nx = XSW'(1);
    end else if (32'(cols_q) > GRID_X) begin
      nx = XSW'(GRID_X);
    end else begin
      nx = XSW'(cols_q);
    end
    if (rows_q == '0) begin
      ny = YSW'(1);
    end else if (32'(rows_q) > GRID_Y) begin
      ny = YSW'(GRID_Y);
    end else begin
      ny = YSW'(rows_q);
    end
  end

  // query maxima clamp to the last cell in use
  always_comb begin
    if (32'(item_i.box_max_x) >= 32'(nx)) begin
      qx1 = XW'(32'(nx) - 32'd1);
    end else begin
      qx1 = XW'(item_i.box_max_x);
    end
    if (32'(item_i.box_max_y) >= 32'(ny)) begin
      qy1 = YW'(32'(ny) - 32'd1);
    end else begin
      qy1 = YW'(item_i.box_max_y);
    end
    qsx     = XW'(32'(item_i.box_min_x) - 32'd1);
    qsy     = YW'(32'(item_i.box_min_y) - 32'd1);
    qvalid  = (32'(item_i.box_min_x) <= 32'(qx1)) && (32'(item_i.box_min_y) <= 32'(qy1));
    mark_ok = (32'(item_i.cell_x) < 32'(nx)) && (32'(item_i.cell_y) < 32'(ny));
  end

  assign bx_first = (px_q == '0);
  assign by_first = (py_q == '0);
  assign last_x   = (32'(px_q) == 32'(nx) - 32'd1);
  assign last_y   = (32'(py_q) == 32'(ny) - 32'd1);

  // sequencer
  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    caddr_d     = caddr_q;
    px_d        = px_q;
    py_d        = py_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    use_d       = use_q;
    lp_d        = lp_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = '0;
    ram_wdata   = '0;
    acc_ctrl    = '0;
    acc_opnd    = ram_rdata;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ph_d = STEP0;
          case (item_i.mode)
            MODE_CLEAR: begin
              caddr_d = '0;
              state_d = S_CLEAR;
            end
            MODE_MARK: begin
              px_d    = XW'(item_i.cell_x);
              py_d    = YW'(item_i.cell_y);
              use_d   = {3'b000, mark_ok};
              state_d = S_MARK;
            end
            MODE_BUILD: begin
              px_d    = '0;
              py_d    = '0;
              state_d = S_BUILD;
            end
            MODE_QUERY: begin
              px_d    = qx1;
              py_d    = qy1;
              sx_d    = qsx;
              sy_d    = qsy;
              // terms: max corner, left strip, bottom strip, corner add-back
              use_d[0] = qvalid;
              use_d[1] = qvalid && (item_i.box_min_x != '0);
              use_d[2] = qvalid && (item_i.box_min_y != '0);
              use_d[3] = qvalid && (item_i.box_min_x != '0) && (item_i.box_min_y != '0);
              state_d  = S_QUERY;
            end
            default: ;
          endcase
        end
      end

      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = caddr_q;
        ram_wdata = '0;
        caddr_d   = caddr_q + AW'(1);
        if (caddr_q == '1) begin
          state_d = S_IDLE;
        end
      end

      S_MARK: begin
        // out-of-range marks are dropped
        ram_we    = use_q[0];
        ram_addr  = {px_q, py_q};
        ram_wdata = CNT_W'(1);
        state_d   = S_IDLE;
      end

      S_BUILD: begin
        // acc carries the cell below between cells of one column
        ph_d = ph_q + 3'd1;
        case (ph_q)
          STEP0: begin
            ram_re       = 1'b1;
            ram_addr     = {px_q, py_q};
            acc_ctrl.clr = by_first;
          end
          STEP1: begin
            ram_re      = !bx_first;
            ram_addr    = {px_q - XW'(1), py_q};
            acc_ctrl.en = 1'b1;
          end
          STEP2: begin
            acc_ctrl.en  = !bx_first && !by_first;
            acc_ctrl.sub = 1'b1;
            acc_opnd     = lp_q;
          end
          STEP3: begin
            acc_ctrl.en = !bx_first;
            lp_d        = ram_rdata;
          end
          STEP4: begin
            ram_we    = 1'b1;
            ram_addr  = {px_q, py_q};
            ram_wdata = acc_val;
            ph_d      = STEP0;
            if (last_y) begin
              py_d = '0;
              if (last_x) begin
                state_d = S_IDLE;
              end else begin
                px_d = px_q + XW'(1);
              end
            end else begin
              py_d = py_q + YW'(1);
            end
          end
          default: ph_d = STEP0;
        endcase
      end

      S_QUERY: begin
        // read issued in one step is accumulated in the next
        ph_d = ph_q + 3'd1;
        case (ph_q)
          STEP0: begin
            ram_re       = use_q[0];
            ram_addr     = {px_q, py_q};
            acc_ctrl.clr = 1'b1;
          end
          STEP1: begin
            ram_re      = use_q[1];
            ram_addr    = {sx_q, py_q};
            acc_ctrl.en = use_q[0];
          end
          STEP2: begin
            ram_re       = use_q[2];
            ram_addr     = {px_q, sy_q};
            acc_ctrl.en  = use_q[1];
            acc_ctrl.sub = 1'b1;
          end
          STEP3: begin
            ram_re       = use_q[3];
            ram_addr     = {sx_q, sy_q};
            acc_ctrl.en  = use_q[2];
            acc_ctrl.sub = 1'b1;
          end
          STEP4: begin
            acc_ctrl.en = use_q[3];
            state_d     = S_RESULT;
          end
          default: ph_d = STEP0;
        endcase
      end

      S_RESULT: begin
        res_d.occupied_count = acc_val;
        res_d.box_empty      = (acc_val == '0);
        res_valid_d          = 1'b1;
        state_d              = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ph_q        <= STEP0;
      caddr_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      caddr_q     <= caddr_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    px_q  <= px_d;
    py_q  <= py_d;
    sx_q  <= sx_d;
    sy_q  <= sy_d;
    use_q <= use_d;
    lp_q  <= lp_d;
    res_q <= res_d;
  end

  osabq_ram #(
    .WIDTH (CNT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  osabq_acc u_acc (
    .clk_i  (clk_i),
    .ctrl_i (acc_ctrl),
    .opnd_i (acc_opnd),
    .acc_o  (acc_val)
  );

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // checks
  `OSABQ_ASSERT_NEXT(a_result_follows, state_q == S_RESULT, res_valid_o, "missing result strobe")
  `OSABQ_ASSERT_IMPL(a_result_source, res_valid_o, $past(state_q == S_RESULT), "stray result strobe")
  `OSABQ_ASSERT_IMPL(a_empty_flag, res_valid_o,
                     res_o.box_empty == (res_o.occupied_count == '0), "empty flag mismatch")
  `OSABQ_ASSERT_IMPL(a_query_no_write, state_q == S_QUERY, !ram_we, "ram write during query")
  `OSABQ_ASSERT_NEXT(a_item_leaves_idle, start_i && !busy_o, busy_o, "accepted item left idle")

endmodule

// File: tb/tb_top.sv
// testbench for occupancy_summed_area_box_query: directed and random clear, mark,
// build and query items, each query result checked against an in-bench grid model
// depends on osabq_pkg and the occupancy_summed_area_box_query rtl
module tb_top;
  import osabq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_X = 256;
  localparam int GRID_Y = 256;
  localparam int ITEM_TARGET = 1750;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // dut ports, all driven from time zero
  logic                 start_i = 1'b0;
  logic                 busy_o;
  in_t                  item_i = '0;
  logic                 res_valid_o;
  out_t                 res_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  occupancy_summed_area_box_query #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .item_i      (item_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // grid model: raw marks or prefix sums, 17-bit wrapping like the hardware
  logic [CNT_W-1:0] grid_sums [GRID_X][GRID_Y];
  logic [CFG_W-1:0] cols_cfg = 9'd256;
  logic [CFG_W-1:0] rows_cfg = 9'd256;

  in_t  items_to_drive [$];
  out_t expected_counts [$];

  logic took_q = 1'b0;    // item accepted at the last rising edge
  int   sender_idle_pct = 19;
  int   items_sent = 0;
  int   error_count = 0;

  // sizes in use as the block sees them: 0 acts as 1, oversize clips to the grid
  function automatic int eff_dim(input logic [CFG_W-1:0] v, input int grid);
    if (v == '0) return 1;
    if (int'(v) > grid) return grid;
    return int'(v);
  endfunction

  function automatic in_t random_item();
    in_t it;
    it.mode      = mode_e'(2'($urandom_range(3)));
    it.cell_x    = 8'($urandom_range(255));
    it.cell_y    = 8'($urandom_range(255));
    it.box_min_x = 8'($urandom_range(255));
    it.box_min_y = 8'($urandom_range(255));
    it.box_max_x = 8'($urandom_range(255));
    it.box_max_y = 8'($urandom_range(255));
    return it;
  endfunction

  // apply one accepted item to the grid model, queue the count a query yields
  task automatic apply_grid_item(input in_t it);
    int nx, ny, x0, y0, x1, y1;
    logic [CNT_W-1:0] acc;
    out_t res;
    nx = eff_dim(cols_cfg, GRID_X);
    ny = eff_dim(rows_cfg, GRID_Y);
    case (it.mode)
      MODE_CLEAR: begin
        for (int x = 0; x < GRID_X; x++)
          for (int y = 0; y < GRID_Y; y++) grid_sums[x][y] = '0;
      end
      MODE_MARK: begin
        // cells outside the region in use are dropped
        if (int'(it.cell_x) < nx && int'(it.cell_y) < ny)
          grid_sums[it.cell_x][it.cell_y] = 17'd1;
      end
      MODE_BUILD: begin
        // in-place prefix sums over the region in use, row-major in x then y
        for (int x = 0; x < nx; x++) begin
          for (int y = 0; y < ny; y++) begin
            acc = grid_sums[x][y];
            if (x > 0) acc = acc + grid_sums[x-1][y];
            if (y > 0) acc = acc + grid_sums[x][y-1];
            if (x > 0 && y > 0) acc = acc - grid_sums[x-1][y-1];
            grid_sums[x][y] = acc;
          end
        end
      end
      default: begin
        x0 = it.box_min_x;
        y0 = it.box_min_y;
        x1 = it.box_max_x;
        y1 = it.box_max_y;
        if (x1 > nx - 1) x1 = nx - 1;
        if (y1 > ny - 1) y1 = ny - 1;
        acc = '0;
        // empty rectangle after clamping gives zero
        if (x0 <= x1 && y0 <= y1) begin
          acc = grid_sums[x1][y1];
          if (x0 > 0) acc = acc - grid_sums[x0-1][y1];
          if (y0 > 0) acc = acc - grid_sums[x1][y0-1];
          if (x0 > 0 && y0 > 0) acc = acc + grid_sums[x0-1][y0-1];
        end
        res.box_empty      = (acc == '0);
        res.occupied_count = acc;
        expected_counts = {expected_counts, res};
      end
    endcase
  endtask

  // item driver: holds an item until taken, idles at random between items
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && !took_q) begin
      // still waiting for the block to take the item
    end else if (items_to_drive.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
      item_i  <= items_to_drive.pop_front();
      start_i <= 1'b1;
    end else begin
      item_i  <= random_item();
      start_i <= 1'b0;
    end
  end

  // result monitor and model update, both at the rising edge
  always @(posedge clk_i) begin : grid_monitor
    out_t oldest;
    if (!rst_ni) begin
      took_q <= 1'b0;
    end else begin
      // check first: a result at this edge belongs to an earlier query
      if (res_valid_o) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: unexpected result, actual empty %0b count %0d",
                   $time, res_o.box_empty, res_o.occupied_count);
          error_count++;
        end else begin
          oldest = expected_counts.pop_front();
          if (res_o.box_empty !== oldest.box_empty) begin
            $display("%0t: box_empty mismatch, expected %0b actual %0b",
                     $time, oldest.box_empty, res_o.box_empty);
            error_count++;
          end
          if (res_o.occupied_count !== oldest.occupied_count) begin
            $display("%0t: occupied_count mismatch, expected %0d actual %0d",
                     $time, oldest.occupied_count, res_o.occupied_count);
            error_count++;
          end
        end
      end
      if (start_i && !busy_o) begin
        took_q <= 1'b1;
        apply_grid_item(item_i);
      end else begin
        took_q <= 1'b0;
      end
    end
  end

  // queue one item; marks that the block will drop do not count
  task automatic send(input mode_e m, input int a = 0, input int b = 0,
                      input int c = 0, input int d = 0);
    in_t it;
    it = random_item();
    it.mode = m;
    if (m == MODE_MARK) begin
      it.cell_x = 8'(a);
      it.cell_y = 8'(b);
    end
    if (m == MODE_QUERY) begin
      it.box_min_x = 8'(a);
      it.box_min_y = 8'(b);
      it.box_max_x = 8'(c);
      it.box_max_y = 8'(d);
    end
    if (m != MODE_MARK ||
        (a < eff_dim(cols_cfg, GRID_X) && b < eff_dim(rows_cfg, GRID_Y)))
      items_sent++;
    items_to_drive = {items_to_drive, it};
  endtask

  // wait until all items are taken, all counts are back and the block is idle;
  // checked at the rising edge, where the driven inputs have settled
  task automatic wait_idle();
    do @(posedge clk_i);
    while (items_to_drive.size() != 0 || start_i || busy_o || expected_counts.size() != 0);
    @(negedge clk_i);
  endtask

  // one register write; valid is left high so back-to-back writes keep it up
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    if (idx == CFG_COLS) cols_cfg = val;
    else rows_cfg = val;
    @(negedge clk_i);
  endtask

  task automatic end_cfg();
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_IDX_W'($urandom_range(1));
    cfg_data_i  <= CFG_W'($urandom_range(511));
  endtask

  // mostly cells in use, now and then anywhere on the 8-bit range
  task automatic queue_random_mark(input int nx, input int ny);
    if ($urandom_range(9) != 0) send(MODE_MARK, $urandom_range(nx - 1), $urandom_range(ny - 1));
    else send(MODE_MARK, $urandom_range(255), $urandom_range(255));
  endtask

  // one scene: optional clear, marks, usually a build, then queries with a few stray items
  task automatic queue_random_scene(input bit with_clear);
    int nx, ny, n, k, x0, y0, x1, y1;
    nx = eff_dim(cols_cfg, GRID_X);
    ny = eff_dim(rows_cfg, GRID_Y);
    if (with_clear) send(MODE_CLEAR);
    n = $urandom_range(20, 1);
    repeat (n) queue_random_mark(nx, ny);
    // sometimes no build (query on raw marks), sometimes a second one
    k = $urandom_range(19);
    if (k != 0) send(MODE_BUILD);
    if (k == 1) send(MODE_BUILD);
    n = $urandom_range(25, 4);
    repeat (n) begin
      k = $urandom_range(19);
      if (k == 0) begin
        queue_random_mark(nx, ny);
      end else if (k == 1) begin
        // stray item of any kind but clear, which walks the whole ram
        send(mode_e'(2'($urandom_range(3, 1))), $urandom_range(255), $urandom_range(255),
             $urandom_range(255), $urandom_range(255));
      end else begin
        k = $urandom_range(9);
        if (k < 6) begin
          // well-formed rectangle inside the region in use
          x0 = $urandom_range(nx - 1);
          x1 = $urandom_range(nx - 1, x0);
          y0 = $urandom_range(ny - 1);
          y1 = $urandom_range(ny - 1, y0);
        end else if (k < 8) begin
          // anything the fields allow, maxima often clamped
          x0 = $urandom_range(255);
          y0 = $urandom_range(255);
          x1 = $urandom_range(255);
          y1 = $urandom_range(255);
        end else if (k == 8) begin
          // min above max along x
          x0 = $urandom_range(255, 1);
          x1 = $urandom_range(x0 - 1);
          y0 = $urandom_range(255);
          y1 = $urandom_range(255);
        end else begin
          x0 = 0;
          y0 = 0;
          x1 = 255;
          y1 = 255;
        end
        send(MODE_QUERY, x0, y0, x1, y1);
      end
    end
  endtask

  // main stimulus
  initial begin : stimulus
    int k, c, r, big, short_side, clears_left;
    bit with_clear;
    clears_left = 2;
    for (int x = 0; x < GRID_X; x++)
      for (int y = 0; y < GRID_Y; y++) grid_sums[x][y] = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, full 256 by 256 grid: corners, query before and after build
    send(MODE_QUERY, 0, 0, 255, 255);
    send(MODE_MARK, 0, 0);
    send(MODE_MARK, 255, 255);
    send(MODE_MARK, 255, 0);
    send(MODE_MARK, 0, 255);
    send(MODE_MARK, 17, 200);
    send(MODE_QUERY, 0, 0, 0, 0);
    send(MODE_BUILD);
    send(MODE_QUERY, 0, 0, 255, 255);
    send(MODE_QUERY, 255, 255, 255, 255);
    send(MODE_QUERY, 1, 1, 254, 254);
    send(MODE_QUERY, 200, 0, 100, 255);
    // a mark on top of the sums overwrites one entry
    send(MODE_MARK, 5, 5);
    send(MODE_QUERY, 5, 5, 5, 5);

    // sizes of zero act as a single cell
    wait_idle();
    write_cfg(CFG_COLS, 9'd0);
    write_cfg(CFG_ROWS, 9'd0);
    end_cfg();
    send(MODE_CLEAR);
    send(MODE_MARK, 0, 0);
    send(MODE_MARK, 1, 0);
    send(MODE_MARK, 0, 255);
    send(MODE_BUILD);
    send(MODE_BUILD);
    send(MODE_QUERY, 0, 0, 255, 255);
    send(MODE_QUERY, 1, 0, 255, 255);
    send(MODE_QUERY, 0, 1, 0, 0);

    // random scenes, idle rate of the sender changes by thirds
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      if (items_sent >= 2 * ITEM_TARGET / 3) sender_idle_pct = 0;
      else if (items_sent >= ITEM_TARGET / 3) sender_idle_pct = 53;
      else sender_idle_pct = 19;
      // keep builds cheap: small patches or thin strips along one axis
      k = $urandom_range(9);
      if (k < 6) begin
        c = $urandom_range(24, 1);
        r = $urandom_range(24, 1);
      end else begin
        case ($urandom_range(3))
          0:       big = 256;
          1:       big = 511;
          2:       big = $urandom_range(511, 257);
          default: big = $urandom_range(511);
        endcase
        short_side = $urandom_range(3);
        c = (k < 8) ? big : short_side;
        r = (k < 8) ? short_side : big;
      end
      if ($urandom_range(4) != 0) begin
        write_cfg(CFG_COLS, CFG_W'(c));
        write_cfg(CFG_ROWS, CFG_W'(r));
      end
      end_cfg();
      with_clear = clears_left > 0 && $urandom_range(15) == 0;
      if (with_clear) clears_left--;
      queue_random_scene(with_clear);
    end

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (error_count == 0 && expected_counts.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // run limit: reset clear, one full-grid build, a few clears, with wide margin
  initial begin : watchdog
    #80ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/osabq_pkg.sv
rtl/core/osabq_ram.sv
rtl/core/osabq_acc.sv
rtl/core/occupancy_summed_area_box_query.sv
tb/tb_top.sv
